// ===== hdl/radix_suffix_number_parser_core_defines.svh =====
// ---------------------------------------------------------------------------
// radix_suffix_number_parser_core_defines
// Assertion macros shared by the number parser RTL.
// ---------------------------------------------------------------------------
`ifndef RADIX_SUFFIX_NUMBER_PARSER_CORE_DEFINES_SVH
`define RADIX_SUFFIX_NUMBER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RSNP_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("rsnp assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RSNP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("rsnp assertion failed");

`endif

// ===== hdl/rsnp_pkg.sv =====
// ---------------------------------------------------------------------------
// rsnp_pkg
// Types, codes and limits for the ASCII radix number parser.
// ---------------------------------------------------------------------------
package rsnp_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_UP_A  = 8'd65;
  localparam logic [7:0] CHAR_UP_F  = 8'd70;
  localparam logic [7:0] CHAR_LO_A  = 8'd97;
  localparam logic [7:0] CHAR_LO_F  = 8'd102;
  localparam logic [7:0] CHAR_SUF_H = 8'd72;
  localparam logic [7:0] CHAR_SUF_D = 8'd68;
  localparam logic [7:0] CHAR_SUF_O = 8'd79;
  localparam logic [7:0] CHAR_SUF_B = 8'd66;

  localparam logic [1:0] RADIX_HEX = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_BIN = 2'd3;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX  = 3'd2;
  localparam logic [2:0] ERR_BAD_DEC  = 3'd3;
  localparam logic [2:0] ERR_BAD_OCT  = 3'd4;
  localparam logic [2:0] ERR_BAD_BIN  = 3'd5;
  localparam logic [2:0] ERR_TOO_LONG = 3'd6;

  localparam logic [29:0] DEC_LIMIT = 30'd268435455;
  localparam logic [5:0]  COUNT_MAX = 6'd63;
  localparam logic [5:0]  HEX_MAX_DIGITS = 6'd7;
  localparam logic [5:0]  DEC_MAX_DIGITS = 6'd9;
  localparam logic [5:0]  OCT_MAX_DIGITS = 6'd10;
  localparam logic [5:0]  BIN_MAX_DIGITS = 6'd29;

  // digits_valid bit positions: 0 hex, 1 dec, 2 oct, 3 bin
  typedef struct packed {
    logic [27:0] hex_total;
    logic [29:0] dec_total;
    logic [29:0] oct_total;
    logic [28:0] bin_total;
    logic [5:0]  digit_count;
    logic [3:0]  digits_valid;
  } acc_state_t;

  localparam acc_state_t ACC_RESET = '{
    hex_total: 28'd0, dec_total: 30'd0, oct_total: 30'd0, bin_total: 29'd0,
    digit_count: 6'd0, digits_valid: 4'hF
  };

  typedef struct packed {
    logic [29:0] value;
    logic [1:0]  radix;
    logic [2:0]  error_code;
  } result_t;

  function automatic logic is_dec_char(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_hex_letter(input logic [7:0] c);
    return ((c >= CHAR_UP_A) && (c <= CHAR_UP_F)) ||
           ((c >= CHAR_LO_A) && (c <= CHAR_LO_F));
  endfunction

endpackage

// ===== hdl/rsnp_digit_acc.sv =====
// ---------------------------------------------------------------------------
// rsnp_digit_acc
// Folds one character into the four saturating accumulators.
// ---------------------------------------------------------------------------
module rsnp_digit_acc import rsnp_pkg::*; (
  input  logic [7:0]  char_in,
  input  acc_state_t  cur,
  output acc_state_t  upd
);

  logic        is_dec;
  logic        is_hex;
  logic [3:0]  dec_d;
  logic [3:0]  hex_d;
  logic [32:0] hex_sum;
  logic [33:0] dec_sum;
  logic [32:0] oct_sum;
  logic [29:0] bin_sum;

  always_comb begin
    is_dec = is_dec_char(char_in);
    is_hex = is_hex_letter(char_in);
    dec_d  = char_in[3:0];
    // 'A'/'a' have low nibble 1, so +9 maps both cases to 10..15
    hex_d  = char_in[3:0] + 4'd9;

    hex_sum = {1'b0, cur.hex_total, 4'b0000} + {29'd0, (is_dec ? dec_d : hex_d)};
    dec_sum = {1'b0, cur.dec_total, 3'b000} + {3'b000, cur.dec_total, 1'b0}
            + {30'd0, dec_d};
    oct_sum = {cur.oct_total, 3'b000} + {29'd0, dec_d};
    bin_sum = {cur.bin_total, 1'b0} + {26'd0, dec_d};

    upd = cur;
    if (is_dec) begin
      upd.hex_total = (hex_sum[32:28] != 5'd0) ? '1 : hex_sum[27:0];
      upd.dec_total = (dec_sum[33:30] != 4'd0) ? '1 : dec_sum[29:0];
      if (dec_d < 4'd8) begin
        upd.oct_total = (oct_sum[32:30] != 3'd0) ? '1 : oct_sum[29:0];
      end else begin
        upd.digits_valid[2] = 1'b0;
      end
      if (dec_d < 4'd2) begin
        upd.bin_total = bin_sum[29] ? '1 : bin_sum[28:0];
      end else begin
        upd.digits_valid[3] = 1'b0;
      end
    end else if (is_hex) begin
      upd.hex_total    = (hex_sum[32:28] != 5'd0) ? '1 : hex_sum[27:0];
      upd.digits_valid = {3'b000, cur.digits_valid[0]};
    end else begin
      upd.digits_valid = 4'h0;
    end
    if (cur.digit_count != COUNT_MAX) begin
      upd.digit_count = cur.digit_count + 6'd1;
    end
  end

endmodule

// ===== hdl/rsnp_resolve.sv =====
// ---------------------------------------------------------------------------
// rsnp_resolve
// Picks the base on the final character and checks digits and limits.
// ---------------------------------------------------------------------------
module rsnp_resolve import rsnp_pkg::*; (
  input  logic [7:0]  char_in,
  input  acc_state_t  cur,
  input  acc_state_t  upd,
  output result_t     res
);

  logic       is_suffix;
  logic       known;
  logic [1:0] base;
  acc_state_t st;

  always_comb begin
    is_suffix = 1'b1;
    base      = RADIX_HEX;
    case (char_in)
      CHAR_SUF_H: base = RADIX_HEX;
      CHAR_SUF_D: base = RADIX_DEC;
      CHAR_SUF_O: base = RADIX_OCT;
      CHAR_SUF_B: base = RADIX_BIN;
      default: begin
        is_suffix = 1'b0;
        base      = is_dec_char(char_in) ? RADIX_DEC : RADIX_HEX;
      end
    endcase
    known = is_suffix || is_dec_char(char_in) || is_hex_letter(char_in);
    // a suffix is not a digit; otherwise the final char was folded in
    st = is_suffix ? cur : upd;

    res = '{value: 30'd0, radix: RADIX_HEX, error_code: ERR_OK};
    if (!known) begin
      res.error_code = ERR_UNKNOWN;
    end else begin
      res.radix = base;
      if (!st.digits_valid[base]) begin
        res.error_code = ERR_BAD_HEX + {1'b0, base};
      end else begin
        case (base)
          RADIX_HEX: begin
            if (st.digit_count > HEX_MAX_DIGITS) res.error_code = ERR_TOO_LONG;
            else res.value = {2'b00, st.hex_total};
          end
          RADIX_DEC: begin
            if ((st.dec_total > DEC_LIMIT) || (st.digit_count > DEC_MAX_DIGITS))
              res.error_code = ERR_TOO_LONG;
            else res.value = st.dec_total;
          end
          RADIX_OCT: begin
            if (st.digit_count > OCT_MAX_DIGITS) res.error_code = ERR_TOO_LONG;
            else res.value = st.oct_total;
          end
          default: begin
            if (st.digit_count > BIN_MAX_DIGITS) res.error_code = ERR_TOO_LONG;
            else res.value = {1'b0, st.bin_total};
          end
        endcase
      end
    end
  end

endmodule

// ===== hdl/radix_suffix_number_parser_core.sv =====
// ---------------------------------------------------------------------------
// radix_suffix_number_parser_core
// ASCII number parser: hex, decimal, octal and binary with optional suffix.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  in_     | in  | in_tvalid/in_tready | tdata: char_in; tlast: is_final
//  out_    | out | out_tvalid/out_tready | tdata: value; tuser: radix, error
//
//  One beat per cycle, sustained unless a final character waits on a busy
//  result slot. A final character beat sits in the input register while
//  the accumulate/resolve logic feeds its result into the result register.
//  The accumulator update is a loop through the accumulator register alone,
//  which sets the rate at one character.
//  Reset (rst_n low, synchronous) empties both registers and clears the
//  accumulators. A stalled result blocks only a following final character;
//  other characters keep flowing into the accumulators.
//
`include "radix_suffix_number_parser_core_defines.svh"

module radix_suffix_number_parser_core import rsnp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // is_final
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [29:0] value, [31:30] zero
  output logic [4:0]  out_tuser   // [1:0] radix, [4:2] error_code
);

  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_final_r;
  acc_state_t acc_r;
  acc_state_t acc_upd;
  result_t    res;
  result_t    out_r;
  logic       out_valid_r;
  logic       adv;

  // the held char moves on unless it is final and the result slot is busy
  assign adv       = in_valid_r && (!in_final_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  rsnp_digit_acc u_acc (
    .char_in (in_char_r),
    .cur     (acc_r),
    .upd     (acc_upd)
  );

  rsnp_resolve u_res (
    .char_in (in_char_r),
    .cur     (acc_r),
    .upd     (acc_upd),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r  <= in_tdata;
      in_final_r <= in_tlast;
    end
  end

  // accumulators clear after each final character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= ACC_RESET;
    end else if (adv) begin
      acc_r <= in_final_r ? ACC_RESET : acc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && in_final_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_final_r) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.value};
  assign out_tuser  = {out_r.error_code, out_r.radix};

  `RSNP_ASSERT_IMPL(a_err_zero_value, clk, rst_n,
    out_valid_r && (out_r.error_code != ERR_OK), out_r.value == 30'd0)
  `RSNP_ASSERT_NEXT(a_final_gives_result, clk, rst_n,
    adv && in_final_r, out_valid_r)
  `RSNP_ASSERT_NEXT(a_final_clears_acc, clk, rst_n,
    adv && in_final_r, acc_r == ACC_RESET)
  `RSNP_ASSERT_IMPL(a_hold_only_on_busy, clk, rst_n,
    in_valid_r && !adv, in_final_r && out_valid_r && !out_tready)

endmodule

// ===== tb/sv/tb_radix_suffix_number_parser_core.sv =====
// ---------------------------------------------------------------------------
// tb_radix_suffix_number_parser_core
// Self-checking bench for the ASCII radix number parser. A short table of
// hand-picked character beats (suffixes, bad digits, unknown bases, empty
// numbers) runs first, then random words, mostly well-formed numbers of a
// random base and length, the rest noise. Every accepted beat is run
// through a local parser model and each result beat is compared with the
// oldest expected one. Source and sink idle in several phases, and one
// phase holds the sink off long enough to back the core up.
// ---------------------------------------------------------------------------
module tb_radix_suffix_number_parser_core;
  import rsnp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_BEATS   = 1080;   // random beats after the table
  localparam int HOLD_CYCLES  = 300;    // long sink hold-off
  localparam int DRAIN_CYCLES = 8;      // two-stage core, plus margin

  // Saturation caps of the running totals
  localparam logic [31:0] HEX_CAP = 32'h0FFF_FFFF;
  localparam logic [31:0] DEC_CAP = 32'h3FFF_FFFF;
  localparam logic [31:0] OCT_CAP = 32'h3FFF_FFFF;
  localparam logic [31:0] BIN_CAP = 32'h1FFF_FFFF;

  typedef enum int {
    PH_STEADY, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH_IDLE, PH_BACKPRESSURE, PH_COUNT
  } phase_e;

  // One row of the directed table; typed rows carry a hand-written result
  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        typed;
    logic [29:0] value;
    logic [1:0]  radix;
    logic [2:0]  err;
  } stim_row_t;

  localparam int DIR_N = 25;
  localparam stim_row_t DIR_TAB [DIR_N] = '{
    // lone suffix after reset: empty hex number, value 0
    '{CHAR_SUF_H, 1'b1, 1'b1, 30'd0,  RADIX_HEX, ERR_OK},
    // bare final decimal digit, bare final lowercase hex letter
    '{CHAR_NINE,  1'b1, 1'b1, 30'd9,  RADIX_DEC, ERR_OK},
    '{CHAR_LO_F,  1'b1, 1'b1, 30'd15, RADIX_HEX, ERR_OK},
    // unknown base: letter, zero byte, all-ones byte
    '{"G",        1'b1, 1'b1, 30'd0,  RADIX_HEX, ERR_UNKNOWN},
    '{8'h00,      1'b1, 1'b1, 30'd0,  RADIX_HEX, ERR_UNKNOWN},
    '{8'hFF,      1'b1, 1'b1, 30'd0,  RADIX_HEX, ERR_UNKNOWN},
    // illegal digit for the suffix base
    '{"8",        1'b0, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    '{CHAR_SUF_O, 1'b1, 1'b1, 30'd0,  RADIX_OCT, ERR_BAD_OCT},
    '{"2",        1'b0, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    '{CHAR_SUF_B, 1'b1, 1'b1, 30'd0,  RADIX_BIN, ERR_BAD_BIN},
    '{CHAR_UP_A,  1'b0, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    '{CHAR_SUF_D, 1'b1, 1'b1, 30'd0,  RADIX_DEC, ERR_BAD_DEC},
    '{"z",        1'b0, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    '{CHAR_SUF_H, 1'b1, 1'b1, 30'd0,  RADIX_HEX, ERR_BAD_HEX},
    // mixed-case hex ending in a letter, no suffix
    '{CHAR_LO_A,  1'b0, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    '{CHAR_UP_F,  1'b1, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    // binary with suffix
    '{"1",        1'b0, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    '{CHAR_ZERO,  1'b0, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    '{"1",        1'b0, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    '{CHAR_SUF_B, 1'b1, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    // remaining lone suffixes
    '{CHAR_SUF_D, 1'b1, 1'b1, 30'd0,  RADIX_DEC, ERR_OK},
    '{CHAR_SUF_O, 1'b1, 1'b1, 30'd0,  RADIX_OCT, ERR_OK},
    '{CHAR_SUF_B, 1'b1, 1'b1, 30'd0,  RADIX_BIN, ERR_OK},
    // high-bit junk kills every base; final digit then picks decimal
    '{8'h80,      1'b0, 1'b0, 30'd0,  RADIX_HEX, ERR_OK},
    '{"7",        1'b1, 1'b1, 30'd0,  RADIX_DEC, ERR_BAD_DEC}
  };

  // DUT ports, bench-driven inputs known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] char_in
  logic        in_tlast   = 1'b0;   // is_final
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [29:0] value, [31:30] zero
  logic [4:0]  out_tuser;           // [1:0] radix, [4:2] error_code

  // Bench state
  acc_state_t acc = ACC_RESET;      // parser model accumulators
  result_t    results_due[$];       // expected result beats, oldest first
  int         err_cnt        = 0;
  int         cycle_cnt      = 0;
  int         beats_sent     = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_req       = 0;   // bumped by the stimulus to ask for a hold
  int         hold_seen      = 0;
  int         hold_left      = 0;

  radix_suffix_number_parser_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Parser model
  // -------------------------------------------------------------------------
  function automatic logic char_is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic char_is_hexletter(input logic [7:0] c);
    return ((c >= CHAR_UP_A) && (c <= CHAR_UP_F)) || ((c >= CHAR_LO_A) && (c <= CHAR_LO_F));
  endfunction

  // total * mult + d, clipped at cap
  function automatic logic [31:0] sat_fold(input logic [31:0] total, input logic [31:0] mult,
                                           input logic [7:0] d, input logic [31:0] cap);
    logic [63:0] t;
    t = {32'd0, total} * {32'd0, mult} + {56'd0, d};
    return (t > {32'd0, cap}) ? cap : t[31:0];
  endfunction

  // Fold one character into every base's total; clear validity where illegal
  task automatic absorb_char(input logic [7:0] c);
    logic [7:0] d;
    if (char_is_digit(c)) begin
      d = c - CHAR_ZERO;
      acc.hex_total = 28'(sat_fold(32'(acc.hex_total), 32'd16, d, HEX_CAP));
      acc.dec_total = 30'(sat_fold(32'(acc.dec_total), 32'd10, d, DEC_CAP));
      if (d < 8'd8) acc.oct_total = 30'(sat_fold(32'(acc.oct_total), 32'd8, d, OCT_CAP));
      else acc.digits_valid[RADIX_OCT] = 1'b0;
      if (d < 8'd2) acc.bin_total = 29'(sat_fold(32'(acc.bin_total), 32'd2, d, BIN_CAP));
      else acc.digits_valid[RADIX_BIN] = 1'b0;
    end else if (char_is_hexletter(c)) begin
      d = (c >= CHAR_LO_A) ? (c - CHAR_LO_A + 8'd10) : (c - CHAR_UP_A + 8'd10);
      acc.hex_total = 28'(sat_fold(32'(acc.hex_total), 32'd16, d, HEX_CAP));
      acc.digits_valid = acc.digits_valid & 4'b0001;   // hex only
    end else begin
      acc.digits_valid = 4'b0000;
    end
    if (acc.digit_count < COUNT_MAX) acc.digit_count = acc.digit_count + 6'd1;
  endtask

  // One accepted input beat; emits a result only on the final character
  task automatic parse_char(input logic [7:0] c, input logic fin,
                            output logic emits, output result_t res);
    logic [1:0] rad;
    logic       known;
    res   = '0;
    emits = 1'b0;
    if (!fin) begin
      absorb_char(c);
    end else begin
      known = 1'b1;
      rad   = RADIX_HEX;
      case (c)
        CHAR_SUF_H: rad = RADIX_HEX;
        CHAR_SUF_D: rad = RADIX_DEC;
        CHAR_SUF_O: rad = RADIX_OCT;
        CHAR_SUF_B: rad = RADIX_BIN;
        default: begin
          // no suffix: the last character is a digit itself
          absorb_char(c);
          if (char_is_digit(c)) rad = RADIX_DEC;
          else if (char_is_hexletter(c)) rad = RADIX_HEX;
          else known = 1'b0;
        end
      endcase
      res.radix = rad;
      if (!known) begin
        res.error_code = ERR_UNKNOWN;
      end else if (!acc.digits_valid[rad]) begin
        res.error_code = ERR_BAD_HEX + 3'(rad);
      end else begin
        case (rad)
          RADIX_HEX: begin
            if (acc.digit_count > HEX_MAX_DIGITS) res.error_code = ERR_TOO_LONG;
            else res.value = 30'(acc.hex_total);
          end
          RADIX_DEC: begin
            // magnitude check comes first, same code either way
            if (acc.dec_total > DEC_LIMIT || acc.digit_count > DEC_MAX_DIGITS)
              res.error_code = ERR_TOO_LONG;
            else res.value = acc.dec_total;
          end
          RADIX_OCT: begin
            if (acc.digit_count > OCT_MAX_DIGITS) res.error_code = ERR_TOO_LONG;
            else res.value = acc.oct_total;
          end
          default: begin
            if (acc.digit_count > BIN_MAX_DIGITS) res.error_code = ERR_TOO_LONG;
            else res.value = 30'(acc.bin_total);
          end
        endcase
      end
      emits = 1'b1;
      acc   = ACC_RESET;   // ready for the next string
    end
  endtask

  // -------------------------------------------------------------------------
  // Source side: drive at negedge, beat taken at the posedge with tready high
  // -------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] c, input logic fin,
                           input logic typed, input result_t want);
    logic    emits;
    result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tlast  = fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_char(c, fin, emits, res);
    if (emits) results_due.push_back(typed ? want : res);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] suffix_of(input logic [1:0] rad);
    case (rad)
      RADIX_HEX: return CHAR_SUF_H;
      RADIX_DEC: return CHAR_SUF_D;
      RADIX_OCT: return CHAR_SUF_O;
      default:   return CHAR_SUF_B;
    endcase
  endfunction

  // One random word: mostly a legal number of a random base, sometimes with
  // one corrupted character, otherwise raw noise
  task automatic send_word();
    int         kind;
    int         len;
    int         lim;
    int         bad_pos;
    int         v;
    logic [1:0] rad;
    logic       use_suffix;
    logic [7:0] ch;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      rad = 2'($urandom_range(0, 3));
      case (rad)
        RADIX_HEX: lim = HEX_MAX_DIGITS;
        RADIX_DEC: lim = DEC_MAX_DIGITS;
        RADIX_OCT: lim = OCT_MAX_DIGITS;
        default:   lim = BIN_MAX_DIGITS;
      endcase
      // mostly around the length limit, a few long enough to pin the count
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 66);
      else len = $urandom_range(0, lim + 2);
      use_suffix = (len == 0) || ($urandom_range(0, 3) != 0);
      bad_pos = (kind == 7) ? $urandom_range(0, len) : -1;
      for (int i = 0; i < len; i++) begin
        case (rad)
          RADIX_HEX: v = $urandom_range(0, 15);
          RADIX_DEC: v = $urandom_range(0, 9);
          RADIX_OCT: v = $urandom_range(0, 7);
          default:   v = $urandom_range(0, 1);
        endcase
        if (i == bad_pos) ch = 8'($urandom_range(0, 255));
        else if (v < 10) ch = CHAR_ZERO + 8'(v);
        else ch = ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + 8'(v - 10);
        send_beat(ch, !use_suffix && (i == len - 1), 1'b0, '0);
      end
      if (use_suffix) send_beat(suffix_of(rad), 1'b1, 1'b0, '0);
    end else begin
      len = $urandom_range(0, 5);
      repeat (len) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      if ($urandom_range(0, 1)) ch = 8'($urandom_range(0, 255));
      else ch = suffix_of(2'($urandom_range(0, 3)));
      send_beat(ch, 1'b1, 1'b0, '0);
    end
  endtask

  // -------------------------------------------------------------------------
  // Sink side: random stalls, plus a long hold-off counted here on request
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result checker: every result beat against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat tdata=%h tuser=%h", $time, out_tdata, out_tuser);
        err_cnt++;
      end else begin
        want = results_due.pop_front();
        if (out_tdata !== {2'b00, want.value}) begin
          $display("%0t: value mismatch: expected %h, actual %h",
                   $time, {2'b00, want.value}, out_tdata);
          err_cnt++;
        end
        if (out_tuser[1:0] !== want.radix) begin
          $display("%0t: radix mismatch: expected %0d, actual %0d",
                   $time, want.radix, out_tuser[1:0]);
          err_cnt++;
        end
        if (out_tuser[4:2] !== want.error_code) begin
          $display("%0t: error_code mismatch: expected %0d, actual %0d",
                   $time, want.error_code, out_tuser[4:2]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    result_t want;
    phase_e  ph;
    // reset held low from time zero, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, no idling
    for (int i = 0; i < DIR_N; i++) begin
      want = '{value: DIR_TAB[i].value, radix: DIR_TAB[i].radix, error_code: DIR_TAB[i].err};
      send_beat(DIR_TAB[i].ch, DIR_TAB[i].fin, DIR_TAB[i].typed, want);
    end

    // random words in idling phases; phases switch on word boundaries
    for (int p = 0; p < PH_COUNT; p++) begin
      ph = phase_e'(p);
      case (ph)
        PH_STEADY:    begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        PH_SRC_IDLE:  begin send_idle_pct = 83; recv_stall_pct = 0;  end
        PH_SNK_STALL: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        PH_BOTH_IDLE: begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin
          // sink held off while the source keeps offering: core backs up
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = hold_req + 1;
        end
      endcase
      while (beats_sent < DIR_N + (p + 1) * RAND_BEATS / PH_COUNT) send_word();
    end
    in_tvalid = 1'b0;

    // drain, then let the pipeline settle
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
